// File: hdl/assert_macros.svh
// Assertion macros used by the checker file cfp_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define CFP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: hdl/cfp_pkg.sv
// Types and constants for the command frame parser.
// No dependencies; imported by the parser and its checker.
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_phase;
    typedef logic [1:0] t_mode;

    localparam t_byte SYNC_BYTE = 8'hBB;
    localparam t_byte TYPE_PET  = 8'h01;
    localparam t_byte TYPE_FEED = 8'h10;
    localparam t_byte TYPE_PLAY = 8'h11;
    localparam t_byte TYPE_STOP = 8'h12;

    localparam t_mode MODE_REST   = 2'd0;
    localparam t_mode MODE_FEED   = 2'd1;
    localparam t_mode MODE_PLAY   = 2'd2;
    localparam t_mode MODE_UNUSED = 2'd3;

    localparam t_phase PH_HUNT      = 3'd0;
    localparam t_phase PH_TYPE      = 3'd1;
    localparam t_phase PH_DATA      = 3'd2;
    localparam t_phase PH_SUM_DATA  = 3'd3;
    localparam t_phase PH_SUM_PLAIN = 3'd4;

endpackage

`default_nettype wire

// File: hdl/command_frame_parser.sv
// Command frame parser: sync 0xBB, type, optional data byte, checksum.
// Depends on cfp_pkg.
//
// channel  | valid        | ready        | payload
// ---------+--------------+--------------+----------------------------------------
// input    | i_in_valid   | o_in_ready   | i_rx_byte
// output   | o_out_valid  | i_out_ready  | o_mode, o_pet_status, o_frame_ok,
//          |              |              | o_checksum_error
//
// One byte per cycle unless the output stalls; the output register takes its result on
// acceptance. Input is ready whenever the output register is empty or being taken.
// A stalled output holds its result and blocks input; parser state is unchanged.
// Synchronous active-low reset: hunting for sync, mode idle, pet status zero.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_parser
    import cfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_mode,
    output logic [7:0]      o_pet_status,
    output logic            o_frame_ok,
    output logic            o_checksum_error
);

    t_phase r_phase, n_phase;
    t_byte  r_type,  n_type;
    t_byte  r_data,  n_data;
    t_mode  r_mode,  n_mode;
    t_byte  r_pet,   n_pet;
    logic   n_ok, n_err;

    logic   r_out_valid;
    t_mode  r_out_mode;
    t_byte  r_out_pet;
    logic   r_out_ok;
    logic   r_out_err;

    logic   w_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_data  = r_data;
        n_mode  = r_mode;
        n_pet   = r_pet;
        n_ok    = 1'b0;
        n_err   = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                if (i_rx_byte == SYNC_BYTE) begin
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_type  = i_rx_byte;
                n_phase = (i_rx_byte == TYPE_PET) ? PH_DATA : PH_SUM_PLAIN;
            end
            PH_DATA: begin
                n_data  = i_rx_byte;
                n_phase = PH_SUM_DATA;
            end
            PH_SUM_DATA: begin
                if (i_rx_byte == (r_type ^ r_data)) begin
                    n_ok = 1'b1;
                    if (r_type == TYPE_PET) begin
                        n_pet = r_data;
                    end
                end else begin
                    n_err = 1'b1;
                end
                n_phase = PH_HUNT;
            end
            PH_SUM_PLAIN: begin
                if (i_rx_byte == r_type) begin
                    n_ok = 1'b1;
                    case (r_type)
                        TYPE_FEED: n_mode = MODE_FEED;
                        TYPE_PLAY: n_mode = MODE_PLAY;
                        TYPE_STOP: n_mode = MODE_REST;
                        default:   n_mode = r_mode;
                    endcase
                end else begin
                    n_err = 1'b1;
                end
                n_phase = PH_HUNT;
            end
            default: begin
                // unreachable codes drop the byte
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_type      <= '0;
            r_data      <= '0;
            r_mode      <= MODE_REST;
            r_pet       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase     <= n_phase;
                r_type      <= n_type;
                r_data      <= n_data;
                r_mode      <= n_mode;
                r_pet       <= n_pet;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_mode <= n_mode;
            r_out_pet  <= n_pet;
            r_out_ok   <= n_ok;
            r_out_err  <= n_err;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mode           = r_out_mode;
    assign o_pet_status     = r_out_pet;
    assign o_frame_ok       = r_out_ok;
    assign o_checksum_error = r_out_err;

endmodule

`default_nettype wire

// File: hdl/cfp_checker.sv
// Port-level checker for the command frame parser, bound to command_frame_parser.
// Depends on cfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cfp_checker
    import cfp_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_mode,
    input wire logic [7:0] o_pet_status,
    input wire logic       o_frame_ok,
    input wire logic       o_checksum_error
);

    // a frame cannot both pass and fail
    `CFP_ASSERT_NEVER(a_flags_excl, i_clk, i_rst_n, o_out_valid && o_frame_ok && o_checksum_error, "frame_ok and checksum_error both set")

    `CFP_ASSERT_NEVER(a_mode_code, i_clk, i_rst_n, o_out_valid && (o_mode == MODE_UNUSED), "mode shows unused code")

    // empty output register must never block input
    `CFP_ASSERT(a_ready_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "input stalled with empty output")

    // a new result shows only after an input transaction
    `CFP_ASSERT(a_valid_src, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready), "result without input transaction")

    `CFP_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_mode) && $stable(o_pet_status) && $stable(o_frame_ok) && $stable(o_checksum_error)), "stalled result changed")

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_mode           (o_mode),
    .o_pet_status     (o_pet_status),
    .o_frame_ok       (o_frame_ok),
    .o_checksum_error (o_checksum_error)
);

`default_nettype wire

// File: tb/tb_command_frame_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for command_frame_parser: a directed table, then random frames.
// Every accepted byte runs through a local parser model; each result is checked against
// it or the row's wanted status. Depends on cfp_pkg and the command_frame_parser RTL.
module tb_command_frame_parser;
    import cfp_pkg::*;

    localparam int STALL_LIMIT    = 1000;
    localparam int ITEMS_PER_STEP = 340;

    typedef struct packed {
        t_mode mode;
        t_byte pet;
        logic  ok;
        logic  err;
    } status_t;

    // typed = 1: the wanted status is given in the row, otherwise the model supplies it
    typedef struct {
        t_byte   b;
        bit      typed;
        status_t want;
    } txn_t;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    t_byte rx_byte   = '0;
    logic  out_ready = 1'b0;
    wire   in_ready;
    wire   out_valid;
    wire [1:0] mode;
    wire [7:0] pet_status;
    wire   frame_ok;
    wire   checksum_error;

    txn_t    tx_bytes[$];
    status_t pending_status[$];
    int      n_fail        = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      stall_cycles  = 0;

    // parser model state
    t_phase m_phase = PH_HUNT;
    t_byte  m_type  = '0;
    t_byte  m_data  = '0;
    t_mode  m_mode  = MODE_REST;
    t_byte  m_pet   = '0;

    always #5 clk = ~clk;

    command_frame_parser i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_mode           (mode),
        .o_pet_status     (pet_status),
        .o_frame_ok       (frame_ok),
        .o_checksum_error (checksum_error)
    );

    task automatic advance_parser(input t_byte b, output status_t s);
        logic ok;
        logic err;
        ok  = 1'b0;
        err = 1'b0;
        case (m_phase)
            PH_HUNT: begin
                if (b == SYNC_BYTE) m_phase = PH_TYPE;
            end
            PH_TYPE: begin
                m_type  = b;
                m_phase = (b == TYPE_PET) ? PH_DATA : PH_SUM_PLAIN;
            end
            PH_DATA: begin
                m_data  = b;
                m_phase = PH_SUM_DATA;
            end
            PH_SUM_DATA: begin
                if (b == (m_type ^ m_data)) begin
                    ok = 1'b1;
                    if (m_type == TYPE_PET) m_pet = m_data;
                end else begin
                    err = 1'b1;
                end
                m_phase = PH_HUNT;
            end
            PH_SUM_PLAIN: begin
                if (b == m_type) begin
                    ok = 1'b1;
                    case (m_type)
                        TYPE_FEED: m_mode = MODE_FEED;
                        TYPE_PLAY: m_mode = MODE_PLAY;
                        TYPE_STOP: m_mode = MODE_REST;
                        default: ;
                    endcase
                end else begin
                    err = 1'b1;
                end
                m_phase = PH_HUNT;
            end
            default: m_phase = PH_HUNT;
        endcase
        s = '{m_mode, m_pet, ok, err};
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    task automatic push_byte(input t_byte b);
        tx_bytes.push_back('{b, 1'b0, '0});
    endtask

    // One random frame, sometimes corrupted or cut short; or a burst of line noise.
    // n returns the number of bytes queued.
    task automatic queue_random_frame(output int n);
        int    pick;
        int    noise;
        t_byte ftype;
        t_byte fdata;
        t_byte fsum;
        n = 0;
        if ($urandom_range(5) == 0) begin
            noise = $urandom_range(1, 3);
            repeat (noise) push_byte(t_byte'($urandom_range(255)));
            n = noise;
        end else begin
            pick = $urandom_range(9);
            case (pick)
                0, 1, 2: ftype = TYPE_PET;
                3:       ftype = TYPE_FEED;
                4:       ftype = TYPE_PLAY;
                5:       ftype = TYPE_STOP;
                6:       ftype = SYNC_BYTE;
                default: ftype = t_byte'($urandom_range(255));
            endcase
            fdata = t_byte'($urandom_range(255));
            fsum  = (ftype == TYPE_PET) ? (ftype ^ fdata) : ftype;
            if ($urandom_range(6) == 0) fsum = fsum ^ t_byte'($urandom_range(1, 255));
            push_byte(SYNC_BYTE);
            push_byte(ftype);
            n = 2;
            if (ftype == TYPE_PET) begin
                push_byte(fdata);
                n++;
            end
            // truncated frame: the next frame's bytes get parsed as its tail
            if ($urandom_range(24) != 0) begin
                push_byte(fsum);
                n++;
            end
        end
    endtask

    // input side: present queued bytes, predict on each accepted transaction
    always @(posedge clk) begin : drive_proc
        status_t s;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                advance_parser(tx_bytes[0].b, s);
                pending_status.push_back(tx_bytes[0].typed ? tx_bytes[0].want : s);
                void'(tx_bytes.pop_front());
            end
            if (!in_valid || in_ready) begin
                if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    rx_byte  <= tx_bytes[0].b;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: random back-pressure, compare against oldest pending status
    always @(posedge clk) begin : check_proc
        status_t want;
        if (rst_n) begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (out_valid && out_ready) begin
                if (pending_status.size() == 0) begin
                    $error("result transaction with no expected status pending");
                    n_fail++;
                end else begin
                    want = pending_status.pop_front();
                    check_field("mode", 8'(want.mode), 8'(mode));
                    check_field("pet_status", want.pet, pet_status);
                    check_field("frame_ok", 8'(want.ok), 8'(frame_ok));
                    check_field("checksum_error", 8'(want.err), 8'(checksum_error));
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        txn_t directed_rows[25];
        int   counted;
        int   n;
        directed_rows = '{
            // hunting drops non-sync bytes
            '{8'h00,     1'b1, '{MODE_REST, 8'h00, 1'b0, 1'b0}},
            '{SYNC_BYTE, 1'b1, '{MODE_REST, 8'h00, 1'b0, 1'b0}},
            '{TYPE_PET,  1'b0, '0},
            '{8'hFF,     1'b0, '0},
            '{8'hFE,     1'b1, '{MODE_REST, 8'hFF, 1'b1, 1'b0}},
            '{SYNC_BYTE, 1'b0, '0},
            '{TYPE_FEED, 1'b0, '0},
            '{TYPE_FEED, 1'b1, '{MODE_FEED, 8'hFF, 1'b1, 1'b0}},
            // data frame with a bad checksum
            '{SYNC_BYTE, 1'b0, '0},
            '{TYPE_PET,  1'b0, '0},
            '{8'h55,     1'b0, '0},
            '{8'h00,     1'b1, '{MODE_FEED, 8'hFF, 1'b0, 1'b1}},
            '{SYNC_BYTE, 1'b0, '0},
            '{TYPE_PLAY, 1'b0, '0},
            '{TYPE_PLAY, 1'b1, '{MODE_PLAY, 8'hFF, 1'b1, 1'b0}},
            // sync byte as type and checksum: unknown type, no effect
            '{SYNC_BYTE, 1'b0, '0},
            '{SYNC_BYTE, 1'b0, '0},
            '{SYNC_BYTE, 1'b1, '{MODE_PLAY, 8'hFF, 1'b1, 1'b0}},
            '{SYNC_BYTE, 1'b0, '0},
            '{TYPE_PET,  1'b0, '0},
            '{8'h00,     1'b0, '0},
            '{TYPE_PET,  1'b1, '{MODE_PLAY, 8'h00, 1'b1, 1'b0}},
            '{SYNC_BYTE, 1'b0, '0},
            '{TYPE_STOP, 1'b0, '0},
            '{TYPE_STOP, 1'b1, '{MODE_REST, 8'h00, 1'b1, 1'b0}}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 22;
        recv_idle_pct = 48;
        foreach (directed_rows[i]) tx_bytes.push_back(directed_rows[i]);
        while (tx_bytes.size() != 0) @(posedge clk);

        for (int step = 0; step < 3; step++) begin
            case (step)
                0: begin send_idle_pct = 22; recv_idle_pct = 48; end
                1: begin send_idle_pct = 48; recv_idle_pct = 22; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            counted = 0;
            while (counted < ITEMS_PER_STEP) begin
                queue_random_frame(n);
                counted += n;
            end
            while (tx_bytes.size() != 0) @(posedge clk);
        end

        while (pending_status.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (n_fail == 0 && pending_status.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/cfp_pkg.sv
hdl/command_frame_parser.sv
hdl/cfp_checker.sv
tb/tb_command_frame_parser.sv
